@@ rtl/svr_pkg.sv @@
// Shared types and constants for the state vector RX rotation block.
`timescale 1ns / 1ps
package svr_pkg;

  // Register size and amplitude store geometry.
  localparam int QUBITS = 10;
  localparam int ADDR_W = QUBITS;
  localparam int STORE  = 1 << QUBITS;
  localparam int PAIRS  = STORE / 2;

  // Q2.14 fixed point.
  localparam int AMP_W   = 16;
  localparam int FRAC_W  = 14;
  localparam int TERM_W  = 2 * AMP_W - FRAC_W;
  localparam logic signed [AMP_W-1:0] Q_ONE = 16'sd16384;
  localparam logic signed [2*AMP_W-1:0] Q_HALF_LSB = 32'sd8192;
  localparam logic signed [AMP_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [AMP_W-1:0] SAT_MIN = 16'sh8000;

  // Request codes.
  localparam logic [1:0] REQ_GROUND = 2'd0;
  localparam logic [1:0] REQ_ROTATE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_WRITE  = 2'd3;

  // Status codes.
  localparam logic ST_DONE      = 1'b0;
  localparam logic ST_BAD_TARGET = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_COS_HALF = 1'b0;
  localparam logic REG_SIN_HALF = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [AMP_W-1:0] amp_t;

  // One product request to the shared multiply-accumulate unit.
  typedef struct packed {
    logic go;    // issue a product this cycle
    logic neg;   // subtract this product
    logic last;  // second product of a sum: close and saturate
  } mac_cmd_t;

endpackage

@@ rtl/state_vector_rx_rotation_top.sv @@
// Top level of the state vector RX rotation block: store, sequencer and ports.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid / in_stall): one item carries req_type, target,
//   index, write_re and write_im. Output channel (out_valid / out_stall):
//   exactly one result item per input item: read_re, read_im, status.
//   An item is taken when valid is high and stall is low.
//   The APB port holds cos_half (byte address 0) and sin_half (address 4);
//   write them only while the block is idle.
// A rotation walks every amplitude pair through the single read port of the
// store and the one shared multiplier: two reads, one load, eight products
// plus two drain steps, and two writes per pair. One item is in flight at a
// time; in_stall drops as its result loads, so the next item can then be taken.
// Reset: the block sweeps the store to the ground state (entry 0 = 1.0, all
// others 0), one entry per cycle, with in_stall held high during
// the sweep. cos_half resets to 1.0 and sin_half to 0. APB writes are taken
// at any time. A stalled result holds on out_* and the block does not start
// another item's result until that one is taken.
module state_vector_rx_rotation_top (
  input  logic        clk,
  input  logic        rst,
  // Request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [3:0]  target,
  input  logic [9:0]  index,
  input  logic signed [15:0] write_re,
  input  logic signed [15:0] write_im,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] read_re,
  output logic signed [15:0] read_im,
  output logic        status,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import svr_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_RD0   = 4'd2;
  localparam logic [3:0] S_RD1   = 4'd3;
  localparam logic [3:0] S_LD1   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_WR0   = 4'd6;
  localparam logic [3:0] S_WR1   = 4'd7;
  localparam logic [3:0] S_RDW   = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  localparam logic [3:0] MUL_ISSUE = 4'd8;  // products issued per pair
  localparam logic [3:0] MUL_LAST  = 4'd9;  // last drain step

  logic [3:0] state;

  // Configuration registers.
  amp_t cos_half;
  amp_t sin_half;

  // Amplitude store, {re, im} per entry.
  logic [2*AMP_W-1:0] mem [STORE];
  logic               rd_en;
  addr_t              rd_addr;
  logic [2*AMP_W-1:0] rd_data;
  logic               we;
  addr_t              wa;
  logic [2*AMP_W-1:0] wd;

  // Sequencer registers.
  addr_t      clr;
  logic       resp_pend;
  addr_t      pair;
  logic [3:0] tgt;
  logic [3:0] step;
  logic [1:0] out_cnt;
  amp_t       r0, i0, r1, i1;
  amp_t       n_re0, n_im0, n_re1, n_im1;
  amp_t       res_re, res_im;
  logic       res_st;

  addr_t tmask;
  addr_t low_mask;
  addr_t pair_i;
  addr_t pair_j;
  addr_t req_addr;

  logic in_acc;
  logic cfg_wr;
  logic out_free;

  mac_cmd_t mac_cmd;
  amp_t     mac_coef;
  amp_t     mac_amp;
  amp_t     mac_result;
  logic     mac_done;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign req_addr = ADDR_W'(index);

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SIN_HALF) ? 32'(sin_half) : 32'(cos_half);

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_half <= Q_ONE;
      sin_half <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COS_HALF) begin
        cos_half <= pwdata[AMP_W-1:0];
      end else begin
        sin_half <= pwdata[AMP_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pair addressing: insert a zero at the target bit of the pair count
  // ---------------------------------------------------------------------
  assign tmask    = addr_t'(1) << tgt;
  assign low_mask = tmask - addr_t'(1);
  assign pair_i   = ((pair & ~low_mask) << 1) | (pair & low_mask);
  assign pair_j   = pair_i | tmask;

  // ---------------------------------------------------------------------
  // Store ports
  // ---------------------------------------------------------------------
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pair_i;
    we      = 1'b0;
    wa      = clr;
    wd      = '0;
    case (state)
      S_IDLE: begin
        if (in_acc && req_type == REQ_READ) begin
          rd_en   = 1'b1;
          rd_addr = req_addr;
        end
        if (in_acc && req_type == REQ_WRITE) begin
          we = 1'b1;
          wa = req_addr;
          wd = {write_re, write_im};
        end
      end
      S_CLEAR: begin
        we = 1'b1;
        wa = clr;
        wd = (clr == '0) ? {Q_ONE, AMP_W'(0)} : '0;
      end
      S_RD0: begin
        rd_en   = 1'b1;
        rd_addr = pair_i;
      end
      S_RD1: begin
        rd_en   = 1'b1;
        rd_addr = pair_j;
      end
      S_WR0: begin
        we = 1'b1;
        wa = pair_i;
        wd = {n_re0, n_im0};
      end
      S_WR1: begin
        we = 1'b1;
        wa = pair_j;
        wd = {n_re1, n_im1};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Product schedule for one pair
  //   re0' = c*r0 + s*i1    im0' = c*i0 - s*r1
  //   re1' = s*i0 + c*r1    im1' = c*i1 - s*r0
  // ---------------------------------------------------------------------
  always_comb begin
    mac_cmd.go   = (state == S_MUL) && (step < MUL_ISSUE);
    mac_cmd.neg  = 1'b0;
    mac_cmd.last = step[0];
    mac_coef     = cos_half;
    mac_amp      = r0;
    case (step[2:0])
      3'd0: begin mac_coef = cos_half; mac_amp = r0; end
      3'd1: begin mac_coef = sin_half; mac_amp = i1; end
      3'd2: begin mac_coef = cos_half; mac_amp = i0; end
      3'd3: begin mac_coef = sin_half; mac_amp = r1; mac_cmd.neg = 1'b1; end
      3'd4: begin mac_coef = sin_half; mac_amp = i0; end
      3'd5: begin mac_coef = cos_half; mac_amp = r1; end
      3'd6: begin mac_coef = cos_half; mac_amp = i1; end
      3'd7: begin mac_coef = sin_half; mac_amp = r0; mac_cmd.neg = 1'b1; end
      default: begin mac_coef = cos_half; mac_amp = r0; end
    endcase
  end

  svr_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mac_cmd),
    .coef   (mac_coef),
    .amp    (mac_amp),
    .result (mac_result),
    .done   (mac_done)
  );

  // Collect the four new amplitudes in schedule order.
  always_ff @(posedge clk) begin
    if (mac_done) begin
      case (out_cnt)
        2'd0:    n_re0 <= mac_result;
        2'd1:    n_im0 <= mac_result;
        2'd2:    n_re1 <= mac_result;
        default: n_im1 <= mac_result;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // Payload captures.
    if (state == S_RD1) begin
      r0 <= rd_data[2*AMP_W-1:AMP_W];
      i0 <= rd_data[AMP_W-1:0];
    end
    if (state == S_LD1) begin
      r1 <= rd_data[2*AMP_W-1:AMP_W];
      i1 <= rd_data[AMP_W-1:0];
    end
    if (state == S_RDW) begin
      res_re <= rd_data[2*AMP_W-1:AMP_W];
      res_im <= rd_data[AMP_W-1:0];
    end
    if (in_acc) begin
      tgt    <= target;
      res_re <= '0;
      res_im <= '0;
      res_st <= ST_DONE;
      if (req_type == REQ_ROTATE && {28'd0, target} >= 32'(QUBITS)) begin
        res_st <= ST_BAD_TARGET;
      end
    end
    if (state == S_RESP && out_free) begin
      read_re <= res_re;
      read_im <= res_im;
      status  <= res_st;
    end

    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      resp_pend <= 1'b0;
      pair      <= '0;
      step      <= '0;
      out_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load the result when the output register frees; drop it once taken.
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (mac_done) begin
        out_cnt <= out_cnt + 2'd1;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (req_type)
              REQ_GROUND: begin
                clr       <= '0;
                resp_pend <= 1'b1;
                state     <= S_CLEAR;
              end
              REQ_ROTATE: begin
                if ({28'd0, target} >= 32'(QUBITS)) begin
                  state <= S_RESP;
                end else begin
                  pair  <= '0;
                  state <= S_RD0;
                end
              end
              REQ_READ: begin
                state <= S_RDW;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr <= clr + addr_t'(1);
          if (clr == addr_t'(STORE - 1)) begin
            state <= resp_pend ? S_RESP : S_IDLE;
          end
        end
        S_RD0: begin
          out_cnt <= '0;
          state   <= S_RD1;
        end
        S_RD1: begin
          state <= S_LD1;
        end
        S_LD1: begin
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          step <= step + 4'd1;
          if (step == MUL_LAST) begin
            state <= S_WR0;
          end
        end
        S_WR0: begin
          state <= S_WR1;
        end
        S_WR1: begin
          pair <= pair + addr_t'(1);
          if (pair == addr_t'(PAIRS - 1)) begin
            state <= S_RESP;
          end else begin
            state <= S_RD0;
          end
        end
        S_RDW: begin
          state <= S_RESP;
        end
        S_RESP: begin
          // Hold until the output register is free.
          if (out_free) begin
            resp_pend <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pair_low_half: assert property (@(posedge clk) disable iff (rst)
    state == S_RD0 |-> (pair_i & tmask) == '0)
    else $error("rotation pair base has the target bit set");

  a_mac_in_rotation: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == S_MUL)
    else $error("product result outside the product phase");

  a_four_results: assert property (@(posedge clk) disable iff (rst)
    state == S_WR0 |-> out_cnt == 2'd0 && $past(mac_done))
    else $error("pair written before all four amplitudes were formed");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR && clr == addr_t'(STORE - 1) |=> state != S_CLEAR)
    else $error("store sweep ran past the last entry");

  a_store_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && !in_acc |-> !we && !rd_en)
    else $error("store accessed with no item in progress");

endmodule

@@ rtl/svr_mac.sv @@
// Shared multiply, round and saturating two-term accumulate unit.
`timescale 1ns / 1ps
module svr_mac (
  input  logic              clk,
  input  logic              rst,
  input  svr_pkg::mac_cmd_t cmd,
  input  svr_pkg::amp_t     coef,
  input  svr_pkg::amp_t     amp,
  output svr_pkg::amp_t     result,
  output logic              done
);
  import svr_pkg::*;

  logic signed [2*AMP_W-1:0] prod;
  logic signed [2*AMP_W-1:0] biased;
  logic signed [TERM_W-1:0]  term;
  logic signed [TERM_W-1:0]  sterm;
  logic signed [TERM_W:0]    sum;

  logic signed [TERM_W-1:0] term1;
  logic                     go1;
  logic                     neg1;
  logic                     last1;
  logic signed [TERM_W-1:0] partial;

  // Round to nearest, ties up: floor((a*b + 2^13) / 2^14).
  assign prod   = coef * amp;
  assign biased = prod + Q_HALF_LSB;
  assign term   = biased[2*AMP_W-1:FRAC_W];

  assign sterm = neg1 ? -term1 : term1;
  assign sum   = {partial[TERM_W-1], partial} + {sterm[TERM_W-1], sterm};

  always_ff @(posedge clk) begin
    term1 <= term;
    neg1  <= cmd.neg;
    last1 <= cmd.last;
    if (go1 && !last1) begin
      partial <= sterm;
    end
    if (go1 && last1) begin
      if (sum > (TERM_W+1)'(SAT_MAX)) begin
        result <= SAT_MAX;
      end else if (sum < (TERM_W+1)'(SAT_MIN)) begin
        result <= SAT_MIN;
      end else begin
        result <= sum[AMP_W-1:0];
      end
    end
    if (rst) begin
      go1  <= 1'b0;
      done <= 1'b0;
    end else begin
      go1  <= cmd.go;
      done <= go1 && last1;
    end
  end

endmodule

@@ test/state_vector_rx_rotation_top_tb.sv @@
// Self-checking testbench for the state vector RX rotation block.
`timescale 1ns / 1ps
module state_vector_rx_rotation_top_tb;
  import svr_pkg::*;

  // One expected result item: the amplitude read back, or zero, and a status.
  typedef struct packed {
    amp_t re;
    amp_t im;
    logic st;
  } amp_result_t;

  // Tracks the amplitude vector and coefficients alongside the block and
  // keeps the results still owed, oldest first.
  class rotation_checker;
    amp_t        vec_re [STORE];
    amp_t        vec_im [STORE];
    amp_t        cos_c;
    amp_t        sin_c;
    amp_result_t owed [$];
    int          failures;

    function new();
      ground_state();
      cos_c    = Q_ONE;
      sin_c    = '0;
      failures = 0;
    endfunction

    function void ground_state();
      foreach (vec_re[i]) begin
        vec_re[i] = '0;
        vec_im[i] = '0;
      end
      vec_re[0] = Q_ONE;
    endfunction

    function void set_coeffs(amp_t c, amp_t s);
      cos_c = c;
      sin_c = s;
    endfunction

    // Q2.14 product, rounded to nearest with ties up (floor of t / 2^14).
    function int prod_round(int a, int b);
      longint t;
      t = longint'(a) * longint'(b) + 64'sd8192;
      return int'(t >>> FRAC_W);
    endfunction

    function amp_t sat_add(int p, int q);
      int sum;
      sum = p + q;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      return amp_t'(sum);
    endfunction

    function void rotate_pairs(int tgt);
      int mask;
      int j;
      int c, s, r0, i0, r1, i1;
      mask = 1 << tgt;
      c    = cos_c;
      s    = sin_c;
      for (int i = 0; i < STORE; i++) begin
        if ((i & mask) == 0) begin
          j  = i | mask;
          r0 = vec_re[i];
          i0 = vec_im[i];
          r1 = vec_re[j];
          i1 = vec_im[j];
          vec_re[i] = sat_add(prod_round(c, r0), prod_round(s, i1));
          vec_im[i] = sat_add(prod_round(c, i0), -prod_round(s, r1));
          vec_re[j] = sat_add(prod_round(s, i0), prod_round(c, r1));
          vec_im[j] = sat_add(prod_round(c, i1), -prod_round(s, r0));
        end
      end
    endfunction

    // Apply an accepted request and queue the result it owes.
    function void note_request(logic [1:0] req, logic [3:0] tgt, logic [9:0] idx,
                               amp_t wre, amp_t wim);
      amp_result_t r;
      addr_t       a;
      r.re = '0;
      r.im = '0;
      r.st = ST_DONE;
      a    = addr_t'(idx);
      case (req)
        REQ_GROUND: ground_state();
        REQ_ROTATE: begin
          if (tgt >= QUBITS) r.st = ST_BAD_TARGET;
          else rotate_pairs(tgt);
        end
        REQ_READ: begin
          r.re = vec_re[a];
          r.im = vec_im[a];
        end
        default: begin
          vec_re[a] = wre;
          vec_im[a] = wim;
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(amp_t re, amp_t im, logic st);
      amp_result_t e;
      if (owed.size() == 0) begin
        $error("unexpected result: read_re %0d read_im %0d status %0b", re, im, st);
        failures++;
        return;
      end
      e = owed.pop_front();
      if (re !== e.re) begin
        $error("read_re: expected %0d, got %0d", e.re, re);
        failures++;
      end
      if (im !== e.im) begin
        $error("read_im: expected %0d, got %0d", e.im, im);
        failures++;
      end
      if (st !== e.st) begin
        $error("status: expected %0b, got %0b", e.st, st);
        failures++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [1:0]        req_type  = REQ_GROUND;
  logic [3:0]        target    = '0;
  logic [9:0]        index     = '0;
  logic signed [15:0] write_re = '0;
  logic signed [15:0] write_im = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [15:0] read_re;
  logic signed [15:0] read_im;
  logic              status;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [2:0]        paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  // When set, neither side idles: a stretch of back-to-back traffic.
  bit quiet = 1'b0;

  rotation_checker chk;

  state_vector_rx_rotation_top uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .target   (target),
    .index    (index),
    .write_re (write_re),
    .write_im (write_im),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_re  (read_re),
    .read_im  (read_im),
    .status   (status),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // Result side stalls at random, about 31 percent of the time, unless traffic is quiet.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 31);
  end

  // Note each accepted request; values sampled here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      chk.note_request(req_type, target, index, write_re, write_im);
  end

  // Check each accepted result against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      chk.check_result(read_re, read_im, status);
  end

  // Setup cycle then access cycle; the write lands at the edge with pready high.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write both coefficients (sign-extended) and mirror them in the checker.
  task automatic set_coeffs(input amp_t c, input amp_t s);
    apb_write({REG_COS_HALF, 2'b00}, {{16{c[15]}}, c});
    @(posedge clk);
    apb_write({REG_SIN_HALF, 2'b00}, {{16{s[15]}}, s});
    chk.set_coeffs(c, s);
  endtask

  // Present one item and hold it until the block takes it. in_valid stays
  // high afterward so a following item can go out back to back.
  task automatic send_item(input logic [1:0] req, input logic [3:0] tgt,
                           input logic [9:0] idx, input amp_t wre, input amp_t wim);
    if (!quiet && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    target   <= tgt;
    index    <= idx;
    write_re <= wre;
    write_im <= wim;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic amp_t pick_amp();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return 16'sh7fff;
    if (p < 8) return 16'sh8000;
    if (p < 11) return Q_ONE;
    if (p < 13) return '0;
    return amp_t'($urandom());
  endfunction

  // Mostly small indices so that rotations and reads meet written entries;
  // the rest span the whole store. Rotations are the slow requests, so they
  // are kept to about one item in eight.
  task automatic random_item();
    int         p;
    logic [1:0] req;
    logic [3:0] tgt;
    logic [9:0] idx;
    p = $urandom_range(0, 99);
    if (p < 4) req = REQ_GROUND;
    else if (p < 16) req = REQ_ROTATE;
    else if (p < 58) req = REQ_READ;
    else req = REQ_WRITE;
    if (req == REQ_ROTATE && $urandom_range(0, 99) < 70)
      tgt = 4'($urandom_range(0, QUBITS - 1));
    else
      tgt = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 60) idx = 10'($urandom_range(0, 15));
    else idx = 10'($urandom());
    send_item(req, tgt, idx, pick_amp(), pick_amp());
  endtask

  initial begin
    amp_t cs [6];
    amp_t sn [6];
    chk = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part on reset coefficients (cos 1.0, sin 0): ground contents,
    // field extremes, the lowest and highest out-of-range targets and a ground request.
    send_item(REQ_READ,   4'd0,  10'd0,    16'sd0,     16'sd0);
    send_item(REQ_READ,   4'd15, 10'd1023, 16'sd0,     16'sd0);
    send_item(REQ_WRITE,  4'd0,  10'd0,    16'sh7fff,  16'sh8000);
    send_item(REQ_WRITE,  4'd0,  10'd1023, 16'sh8000,  16'sh7fff);
    send_item(REQ_WRITE,  4'd5,  10'd512,  -16'sd1,    16'sd1);
    send_item(REQ_READ,   4'd0,  10'd0,    16'sd0,     16'sd0);
    send_item(REQ_READ,   4'd0,  10'd1023, 16'sd0,     16'sd0);
    send_item(REQ_READ,   4'd0,  10'd512,  16'sd0,     16'sd0);
    send_item(REQ_ROTATE, 4'd10, 10'd0,    16'sd0,     16'sd0);
    send_item(REQ_ROTATE, 4'd15, 10'd1023, 16'sh7fff,  16'sh7fff);
    send_item(REQ_ROTATE, 4'd9,  10'd0,    16'sd0,     16'sd0);
    send_item(REQ_ROTATE, 4'd0,  10'd0,    16'sd0,     16'sd0);
    send_item(REQ_READ,   4'd0,  10'd1023, 16'sd0,     16'sd0);
    send_item(REQ_READ,   4'd0,  10'd512,  16'sd0,     16'sd0);
    send_item(REQ_GROUND, 4'd3,  10'd77,   16'sd100,   16'sd100);
    send_item(REQ_READ,   4'd0,  10'd0,    16'sd0,     16'sd0);
    send_item(REQ_READ,   4'd0,  10'd1023, 16'sd0,     16'sd0);
    drain();

    // Coefficient settings: 90 degrees, full bit flip, both saturating
    // extremes, both coefficients at -1.0 and one random pair.
    cs[0] = 16'sd11585;  sn[0] = 16'sd11585;
    cs[1] = 16'sd0;      sn[1] = Q_ONE;
    cs[2] = 16'sh8000;   sn[2] = 16'sh7fff;
    cs[3] = 16'sh7fff;   sn[3] = 16'sh8000;
    cs[4] = -Q_ONE;      sn[4] = -Q_ONE;
    cs[5] = amp_t'($urandom_range(0, 32768) - 16384);
    sn[5] = amp_t'($urandom_range(0, 32768) - 16384);

    for (int ph = 0; ph < 6; ph++) begin
      set_coeffs(cs[ph], sn[ph]);
      quiet = (ph == 2);
      // Seed the low entries so that the first rotation has data to mix.
      send_item(REQ_WRITE,  4'd0, 10'd1, pick_amp(), pick_amp());
      send_item(REQ_WRITE,  4'd0, 10'd2, pick_amp(), pick_amp());
      send_item(REQ_ROTATE, 4'($urandom_range(0, 1)), 10'd0, 16'sd0, 16'sd0);
      for (int k = 0; k < 4; k++)
        send_item(REQ_READ, 4'($urandom()), 10'(k), 16'sd0, 16'sd0);
      for (int n = 0; n < 78; n++)
        random_item();
      drain();
    end
    quiet = 1'b0;

    // Let any stray result show up before the verdict.
    repeat (40) @(posedge clk);
    if (chk.failures == 0 && chk.pending() == 0)
      $display("state_vector_rx_rotation_top_tb: clean");
    else
      $display("state_vector_rx_rotation_top_tb: errors");
    $finish;
  end

  // Hard stop: far beyond the slowest correct run of these items.
  initial begin
    #60000000;
    $display("state_vector_rx_rotation_top_tb: errors");
    $finish;
  end

endmodule
